// File: rtl/core/hdlc_nrzi_frame_transmitter_top_macros.svh
// assertion macros used by the hdlc transmitter top level
`ifndef HDLC_NRZI_FRAME_TRANSMITTER_TOP_MACROS_SVH
`define HDLC_NRZI_FRAME_TRANSMITTER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define HDLC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define HDLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/hdlc_tx_pkg.sv
// types, constants and codes of the hdlc nrzi frame transmitter
package hdlc_tx_pkg;

    localparam int MAX_FRAME_BYTES = 512;
    localparam int ADDR_W = $clog2(MAX_FRAME_BYTES);
    localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
    // flag counter must reach 256 preamble flags
    localparam int POS_W = (LEN_W > 9) ? LEN_W : 9;

    localparam logic [7:0] HDLC_FLAG = 8'h7E;
    localparam logic [2:0] STUFF_RUN = 3'd5;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PREAMBLE = 3'd1,
        PH_OPEN     = 3'd2,
        PH_DATA     = 3'd3,
        PH_CLOSE    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        SQ_RUN   = 2'd0,
        SQ_FETCH = 2'd1,
        SQ_LOAD  = 2'd2
    } seq_t;

    typedef struct packed {
        logic line_level;
        logic line_active;
        logic load_accepted;
        logic frame_done;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } store_wr_t;

endpackage

// File: rtl/core/hdlc_nrzi_frame_transmitter_top.sv
// top level of the hdlc nrzi frame transmitter
// Frame transmitter with bit stuffing and NRZI coding. Each input word
// carries an opcode: bit tick, load byte, start frame or stop. Every word
// gives exactly one result word (line level, line active, load accepted,
// frame done). Bytes are loaded while idle into a 512-byte frame store; the
// frame check sequence must already be among them. A start sends
// preamble_flags+1 flags, an opening flag, the bytes lsb first with a zero
// stuffed after five ones, and a closing flag, one bit per tick; a zero
// toggles the line level. Throughput: one word per clock cycle, except a
// word that leaves the transmitter at the start of a data byte, which holds
// off the next word during the byte fetch. These are the tick that ends the
// opening flag, the tick that sends the last bit of a data byte, and any
// other word taken while the transmitter waits at a byte boundary (a
// stuffed zero or an ignored load). The frame store has a single registered
// read port, so the byte is read in the fetch state and loaded into the
// data shift register in the load state; no word is taken in either. The
// result register is separate from the input, so a new word is taken while
// the previous result is still being read out, as long as the result is
// taken in the same cycle. The configuration port is always ready; write
// preamble_flags only while no word is outstanding.
module hdlc_nrzi_frame_transmitter_top (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    // input words
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [7:0] s_data_byte,
    // result words
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_line_level,
    output logic       m_line_active,
    output logic       m_load_accepted,
    output logic       m_frame_done
);

`include "hdlc_nrzi_frame_transmitter_top_macros.svh"

    // preamble flag count register
    logic [7:0] preamble_flags_reg;

    // fetch sequencer: run, then read store, then load shift register
    hdlc_tx_pkg::seq_t seq_reg, seq_next;

    logic item_accept;
    logic rd_en;
    logic byte_load;
    logic fetch_req;
    logic [hdlc_tx_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0] rd_data;

    hdlc_tx_pkg::result_t   res;
    hdlc_tx_pkg::store_wr_t wr;

    // result register
    logic                 m_valid_reg;
    hdlc_tx_pkg::result_t m_res_reg;

    assign cfg_ready   = 1'b1;
    assign item_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preamble_flags_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            preamble_flags_reg <= cfg_data;
        end
    end

    // sequencer next state
    always_comb begin
        seq_next = seq_reg;
        case (seq_reg)
            hdlc_tx_pkg::SQ_RUN: begin
                if (item_accept && fetch_req) begin
                    seq_next = hdlc_tx_pkg::SQ_FETCH;
                end
            end
            hdlc_tx_pkg::SQ_FETCH: begin
                seq_next = hdlc_tx_pkg::SQ_LOAD;
            end
            hdlc_tx_pkg::SQ_LOAD: begin
                seq_next = hdlc_tx_pkg::SQ_RUN;
            end
            default: begin
                seq_next = hdlc_tx_pkg::SQ_RUN;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready   = (seq_reg == hdlc_tx_pkg::SQ_RUN) && (!m_valid_reg || m_ready);
        rd_en     = (seq_reg == hdlc_tx_pkg::SQ_FETCH);
        byte_load = (seq_reg == hdlc_tx_pkg::SQ_LOAD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg <= hdlc_tx_pkg::SQ_RUN;
        end else begin
            seq_reg <= seq_next;
        end
    end

    hdlc_tx_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_accept    (item_accept),
        .opcode         (hdlc_tx_pkg::op_t'(s_opcode)),
        .data_byte      (s_data_byte),
        .preamble_flags (preamble_flags_reg),
        .byte_load      (byte_load),
        .byte_in        (rd_data),
        .res            (res),
        .wr             (wr),
        .fetch_req      (fetch_req),
        .rd_addr        (rd_addr)
    );

    hdlc_tx_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result register, refilled in the cycle it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (item_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_accept) begin
            m_res_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_line_level    = m_res_reg.line_level;
    assign m_line_active   = m_res_reg.line_active;
    assign m_load_accepted = m_res_reg.load_accepted;
    assign m_frame_done    = m_res_reg.frame_done;

    // a byte fetch holds off the next word
    `HDLC_ASSERT_NEXT(a_fetch_stalls, aclk, aresetn,
                      item_accept && fetch_req, !s_ready, "word taken during byte fetch")

    // a finished frame shows up as an active, done result
    `HDLC_ASSERT_NEXT(a_done_result, aclk, aresetn, item_accept && res.frame_done,
                      m_valid && m_frame_done && m_line_active, "frame done result lost")

    // only a load word can store a byte
    `HDLC_ASSERT_NOW(a_load_only, aclk, aresetn, wr.en,
                     item_accept && (s_opcode == hdlc_tx_pkg::OP_LOAD),
                     "store written without a load word")

endmodule

// File: rtl/core/hdlc_tx_store.sv
// frame byte store, one write port and one registered read port
module hdlc_tx_store (
    input  logic                          aclk,
    input  hdlc_tx_pkg::store_wr_t        wr,
    input  logic                          rd_en,
    input  logic [hdlc_tx_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                    rd_data
);

    logic [7:0] mem [hdlc_tx_pkg::MAX_FRAME_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/hdlc_tx_core.sv
// frame sequencing, bit stuffing, nrzi coding and the data shift register
module hdlc_tx_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           item_accept,
    input  hdlc_tx_pkg::op_t               opcode,
    input  logic [7:0]                     data_byte,
    input  logic [7:0]                     preamble_flags,
    input  logic                           byte_load,
    input  logic [7:0]                     byte_in,
    output hdlc_tx_pkg::result_t           res,
    output hdlc_tx_pkg::store_wr_t         wr,
    output logic                           fetch_req,
    output logic [hdlc_tx_pkg::ADDR_W-1:0] rd_addr
);

    hdlc_tx_pkg::phase_t phase_reg, phase_next;
    logic [hdlc_tx_pkg::LEN_W-1:0] len_reg, len_next;
    logic [hdlc_tx_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [2:0] bit_reg, bit_next;
    logic [2:0] ones_reg, ones_next;
    logic       level_reg, level_next;
    logic [7:0] shreg_reg, shreg_next;

    logic                          flag_bit;
    logic                          bit_last;
    logic [hdlc_tx_pkg::POS_W-1:0] pos_inc;
    logic [hdlc_tx_pkg::POS_W-1:0] pf_plus1;
    logic                          load_ok;
    logic                          close_end;

    assign flag_bit = hdlc_tx_pkg::HDLC_FLAG[bit_reg];
    assign bit_last = (bit_reg == 3'd7);
    assign pos_inc  = pos_reg + 1'b1;
    assign pf_plus1 = hdlc_tx_pkg::POS_W'(preamble_flags) + 1'b1;

    assign load_ok = item_accept && (opcode == hdlc_tx_pkg::OP_LOAD)
                     && (phase_reg == hdlc_tx_pkg::PH_IDLE)
                     && (len_reg < hdlc_tx_pkg::LEN_W'(hdlc_tx_pkg::MAX_FRAME_BYTES));
    assign close_end = item_accept && (opcode == hdlc_tx_pkg::OP_TICK)
                       && (phase_reg == hdlc_tx_pkg::PH_CLOSE) && bit_last;

    // next state
    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        bit_next   = bit_reg;
        ones_next  = ones_reg;
        level_next = level_reg;
        shreg_next = shreg_reg;
        if (byte_load) begin
            shreg_next = byte_in;
        end
        if (item_accept) begin
            case (opcode)
                hdlc_tx_pkg::OP_LOAD: begin
                    if (load_ok) begin
                        len_next = len_reg + 1'b1;
                    end
                end
                hdlc_tx_pkg::OP_START: begin
                    if (len_reg != '0) begin
                        pos_next   = '0;
                        bit_next   = '0;
                        ones_next  = '0;
                        level_next = 1'b1;
                        phase_next = hdlc_tx_pkg::PH_PREAMBLE;
                    end else begin
                        phase_next = hdlc_tx_pkg::PH_IDLE;
                    end
                end
                hdlc_tx_pkg::OP_STOP: begin
                    len_next   = '0;
                    phase_next = hdlc_tx_pkg::PH_IDLE;
                end
                hdlc_tx_pkg::OP_TICK: begin
                    case (phase_reg)
                        hdlc_tx_pkg::PH_PREAMBLE: begin
                            if (!flag_bit) begin
                                level_next = ~level_reg;
                                ones_next  = '0;
                            end
                            if (bit_last) begin
                                bit_next = '0;
                                pos_next = pos_inc;
                            end else begin
                                bit_next = bit_reg + 1'b1;
                            end
                            if (pos_next >= pf_plus1) begin
                                pos_next   = '0;
                                bit_next   = '0;
                                phase_next = hdlc_tx_pkg::PH_OPEN;
                            end
                        end
                        hdlc_tx_pkg::PH_OPEN, hdlc_tx_pkg::PH_CLOSE: begin
                            if (!flag_bit) begin
                                level_next = ~level_reg;
                                ones_next  = '0;
                            end
                            if (bit_last) begin
                                pos_next = '0;
                                bit_next = '0;
                                if (phase_reg == hdlc_tx_pkg::PH_OPEN) begin
                                    phase_next = hdlc_tx_pkg::PH_DATA;
                                end else begin
                                    len_next   = '0;
                                    phase_next = hdlc_tx_pkg::PH_IDLE;
                                end
                            end else begin
                                bit_next = bit_reg + 1'b1;
                            end
                        end
                        hdlc_tx_pkg::PH_DATA: begin
                            if (ones_reg >= hdlc_tx_pkg::STUFF_RUN) begin
                                // stuffed zero
                                level_next = ~level_reg;
                                ones_next  = '0;
                            end else begin
                                ones_next  = ones_reg + 1'b1;
                                if (!shreg_reg[0]) begin
                                    level_next = ~level_reg;
                                    ones_next  = '0;
                                end
                                shreg_next = {1'b0, shreg_reg[7:1]};
                                if (bit_last) begin
                                    bit_next = '0;
                                    pos_next = pos_inc;
                                end else begin
                                    bit_next = bit_reg + 1'b1;
                                end
                            end
                            if ((pos_next >= hdlc_tx_pkg::POS_W'(len_reg))
                                && (ones_next < hdlc_tx_pkg::STUFF_RUN)) begin
                                pos_next   = '0;
                                bit_next   = '0;
                                phase_next = hdlc_tx_pkg::PH_CLOSE;
                            end
                        end
                        default: begin
                            phase_next = hdlc_tx_pkg::PH_IDLE;
                        end
                    endcase
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        res.line_level    = level_next;
        res.line_active   = (phase_next != hdlc_tx_pkg::PH_IDLE) || close_end;
        res.load_accepted = load_ok;
        res.frame_done    = close_end;
        wr.en             = load_ok;
        wr.addr           = len_reg[hdlc_tx_pkg::ADDR_W-1:0];
        wr.data           = data_byte;
        fetch_req         = item_accept && (phase_next == hdlc_tx_pkg::PH_DATA)
                            && (bit_next == 3'd0);
        rd_addr           = pos_reg[hdlc_tx_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= hdlc_tx_pkg::PH_IDLE;
            len_reg   <= '0;
            pos_reg   <= '0;
            bit_reg   <= '0;
            ones_reg  <= '0;
            level_reg <= 1'b1;
        end else begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            bit_reg   <= bit_next;
            ones_reg  <= ones_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        shreg_reg <= shreg_next;
    end

endmodule

// File: sim/tb_hdlc_nrzi_frame_transmitter_top.sv
// self-checking testbench for the hdlc nrzi frame transmitter top level
module tb_hdlc_nrzi_frame_transmitter_top;
    timeunit 1ns;
    timeprecision 1ps;

    // run length and guard
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 300;
    localparam int TAIL_CYCLES  = 16;
    localparam int MAX_GAP      = 14;
    localparam int REPORT_LIMIT = 10;

    // clock, reset and block ports; the inputs are known from time zero
    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       cfg_valid       = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data        = 8'h00;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic [1:0] s_opcode        = hdlc_tx_pkg::OP_TICK;
    logic [7:0] s_data_byte     = 8'h00;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic       m_line_level;
    logic       m_line_active;
    logic       m_load_accepted;
    logic       m_frame_done;

    // 12 ns period
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    hdlc_nrzi_frame_transmitter_top uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_line_level    (m_line_level),
        .m_line_active   (m_line_active),
        .m_load_accepted (m_load_accepted),
        .m_frame_done    (m_frame_done)
    );

    // ------------------------------------------------------------------
    // transmitter model: shadow copy of the frame store, the bit
    // sequencer state and the preamble length register
    // ------------------------------------------------------------------
    logic [7:0]           fb_mem [hdlc_tx_pkg::MAX_FRAME_BYTES];
    int                   fb_len       = 0;
    int                   tx_byte_idx  = 0;   // data byte index, or flags sent so far
    int                   tx_bit_idx   = 0;
    int                   ones_count   = 0;
    int                   preamble_cfg = 0;
    logic                 nrzi_level   = 1'b1;
    hdlc_tx_pkg::phase_t  tx_phase     = hdlc_tx_pkg::PH_IDLE;

    // words still owed by the block, oldest first
    hdlc_tx_pkg::result_t pending_results [$];

    // bookkeeping
    int         fail_count   = 0;
    int         items_sent   = 0;
    int         results_seen = 0;
    int         cycle_count  = 0;
    bit         sender_busy  = 1'b1;
    bit         receiver_busy = 1'b1;

    // nrzi: a zero flips the line and breaks the ones run
    function automatic void line_bit(input logic b);
        if (!b) begin
            nrzi_level = ~nrzi_level;
            ones_count = 0;
        end
    endfunction

    // one flag bit; true once the whole flag has gone out
    function automatic logic flag_bit_step();
        line_bit(hdlc_tx_pkg::HDLC_FLAG[tx_bit_idx]);
        if (tx_bit_idx >= 7) begin
            tx_bit_idx = 0;
            tx_byte_idx++;
            return 1'b1;
        end
        tx_bit_idx++;
        return 1'b0;
    endfunction

    // advance the model by one word and return the word the block owes
    function automatic hdlc_tx_pkg::result_t tx_predict(input hdlc_tx_pkg::op_t op,
                                                        input logic [7:0] din);
        logic [7:0]           cur;
        logic                 accepted;
        logic                 done_pulse;
        hdlc_tx_pkg::result_t res;
        accepted   = 1'b0;
        done_pulse = 1'b0;
        case (op)
            hdlc_tx_pkg::OP_LOAD: begin
                // bytes only go in while idle and below capacity
                if (tx_phase == hdlc_tx_pkg::PH_IDLE
                    && fb_len < hdlc_tx_pkg::MAX_FRAME_BYTES) begin
                    fb_mem[fb_len] = din;
                    fb_len++;
                    accepted = 1'b1;
                end
            end
            hdlc_tx_pkg::OP_START: begin
                // empty store: nothing to send; otherwise (re)start at the preamble
                if (fb_len != 0) begin
                    tx_byte_idx = 0;
                    tx_bit_idx  = 0;
                    ones_count  = 0;
                    nrzi_level  = 1'b1;
                    tx_phase    = hdlc_tx_pkg::PH_PREAMBLE;
                end else begin
                    tx_phase = hdlc_tx_pkg::PH_IDLE;
                end
            end
            hdlc_tx_pkg::OP_STOP: begin
                // abort keeps the line level
                fb_len   = 0;
                tx_phase = hdlc_tx_pkg::PH_IDLE;
            end
            default: begin
                case (tx_phase)
                    hdlc_tx_pkg::PH_PREAMBLE: begin
                        void'(flag_bit_step());
                        if (tx_byte_idx >= preamble_cfg + 1) begin
                            tx_byte_idx = 0;
                            tx_bit_idx  = 0;
                            tx_phase    = hdlc_tx_pkg::PH_OPEN;
                        end
                    end
                    hdlc_tx_pkg::PH_OPEN: begin
                        if (flag_bit_step()) begin
                            tx_byte_idx = 0;
                            tx_bit_idx  = 0;
                            tx_phase    = hdlc_tx_pkg::PH_DATA;
                        end
                    end
                    hdlc_tx_pkg::PH_DATA: begin
                        if (ones_count >= int'(hdlc_tx_pkg::STUFF_RUN)) begin
                            line_bit(1'b0);
                        end else begin
                            cur = (tx_byte_idx < hdlc_tx_pkg::MAX_FRAME_BYTES)
                                  ? fb_mem[tx_byte_idx] : 8'h00;
                            ones_count++;
                            line_bit(cur[tx_bit_idx]);
                            if (tx_bit_idx >= 7) begin
                                tx_bit_idx = 0;
                                tx_byte_idx++;
                            end else begin
                                tx_bit_idx++;
                            end
                        end
                        // a pending stuff bit holds off the closing flag
                        if (tx_byte_idx >= fb_len
                            && ones_count < int'(hdlc_tx_pkg::STUFF_RUN)) begin
                            tx_byte_idx = 0;
                            tx_bit_idx  = 0;
                            tx_phase    = hdlc_tx_pkg::PH_CLOSE;
                        end
                    end
                    hdlc_tx_pkg::PH_CLOSE: begin
                        if (flag_bit_step()) begin
                            tx_byte_idx = 0;
                            tx_bit_idx  = 0;
                            fb_len      = 0;
                            tx_phase    = hdlc_tx_pkg::PH_IDLE;
                            done_pulse  = 1'b1;
                        end
                    end
                    default: begin
                        tx_phase = hdlc_tx_pkg::PH_IDLE;
                    end
                endcase
            end
        endcase
        res.line_level    = nrzi_level;
        res.line_active   = (tx_phase != hdlc_tx_pkg::PH_IDLE) || done_pulse;
        res.load_accepted = accepted;
        res.frame_done    = done_pulse;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    function automatic void compare_field(input string field, input logic want,
                                          input logic got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("mismatch on %s, result word %0d: expected %b, got %b",
                         field, results_seen, want, got);
        end
    endfunction

    // receiving side: random back-pressure, one check per accepted word
    initial begin : result_sink
        int                   stall;
        hdlc_tx_pkg::result_t got;
        hdlc_tx_pkg::result_t want;
        wait (aresetn === 1'b1);
        forever begin
            stall = receiver_busy ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            got.line_level    = m_line_level;
            got.line_active   = m_line_active;
            got.load_accepted = m_load_accepted;
            got.frame_done    = m_frame_done;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("result word %0d arrived with nothing expected", results_seen);
            end else begin
                want = pending_results.pop_front();
                compare_field("line_level", want.line_level, got.line_level);
                compare_field("line_active", want.line_active, got.line_active);
                compare_field("load_accepted", want.load_accepted, got.load_accepted);
                compare_field("frame_done", want.frame_done, got.frame_done);
            end
            results_seen++;
        end
    end

    // hang guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one input word; a zero gap keeps valid high straight into this word
    task automatic send_word(input hdlc_tx_pkg::op_t op, input logic [7:0] din);
        int gap;
        gap = sender_busy ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_data_byte <= din;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_results.push_back(tx_predict(op, din));
        items_sent++;
    endtask

    // hold the input side until every owed word has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // preamble length register, only written with the block quiet
    task automatic write_preamble(input logic [7:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        preamble_cfg = value;
        cfg_valid <= 1'b0;
    endtask

    // frame bytes leaning towards long ones runs and flag patterns
    function automatic logic [7:0] pick_frame_byte();
        case ($urandom_range(0, 7))
            0, 1:    return 8'hFF;
            2:       return 8'hF8;   // five ones at the top, lsb first
            3:       return hdlc_tx_pkg::HDLC_FLAG;
            default: return 8'($urandom);
        endcase
    endfunction

    // clock bits out until the frame ends; noisy frames get stray commands
    task automatic tick_out(input bit noisy);
        while (tx_phase != hdlc_tx_pkg::PH_IDLE) begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_word(hdlc_tx_pkg::op_t'($urandom_range(1, 3)), pick_frame_byte());
            else
                send_word(hdlc_tx_pkg::OP_TICK, 8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // commands that must leave an idle, empty block alone
    task automatic test_idle_commands();
        send_word(hdlc_tx_pkg::OP_TICK, 8'h00);
        send_word(hdlc_tx_pkg::OP_START, 8'hFF);    // empty store, stays idle
        send_word(hdlc_tx_pkg::OP_STOP, 8'h00);
        send_word(hdlc_tx_pkg::OP_TICK, 8'hFF);
        send_word(hdlc_tx_pkg::OP_LOAD, 8'h00);
        send_word(hdlc_tx_pkg::OP_STOP, 8'hFF);     // clears the byte just stored
        send_word(hdlc_tx_pkg::OP_START, 8'h00);    // empty again
        send_word(hdlc_tx_pkg::OP_TICK, 8'h00);
    endtask

    // shortest preamble, long ones runs and a data tail ending in five ones
    task automatic test_stuffed_tail();
        write_preamble(8'd0);
        send_word(hdlc_tx_pkg::OP_LOAD, 8'hFF);
        send_word(hdlc_tx_pkg::OP_LOAD, 8'h00);
        send_word(hdlc_tx_pkg::OP_LOAD, 8'hF8);
        send_word(hdlc_tx_pkg::OP_START, 8'h00);
        tick_out(1'b0);
        send_word(hdlc_tx_pkg::OP_TICK, 8'h00);     // idle tick after the done pulse
    endtask

    // load while busy, restart mid-frame, then abort mid-data
    task automatic test_restart_and_abort();
        write_preamble(8'd2);
        send_word(hdlc_tx_pkg::OP_LOAD, hdlc_tx_pkg::HDLC_FLAG);
        send_word(hdlc_tx_pkg::OP_LOAD, 8'h81);
        send_word(hdlc_tx_pkg::OP_START, 8'h00);
        repeat (10) send_word(hdlc_tx_pkg::OP_TICK, 8'($urandom));
        send_word(hdlc_tx_pkg::OP_LOAD, 8'h55);     // ignored, block busy
        send_word(hdlc_tx_pkg::OP_START, 8'h00);    // back to the preamble at mark
        while (tx_phase != hdlc_tx_pkg::PH_DATA)
            send_word(hdlc_tx_pkg::OP_TICK, 8'($urandom));
        repeat (5) send_word(hdlc_tx_pkg::OP_TICK, 8'($urandom));
        send_word(hdlc_tx_pkg::OP_STOP, 8'h00);
        send_word(hdlc_tx_pkg::OP_TICK, 8'h00);
        send_word(hdlc_tx_pkg::OP_START, 8'h00);    // store was emptied by the stop
    endtask

    // fill the store to capacity, overflow it, send a little, abort
    task automatic test_store_full();
        write_preamble(8'd1);
        sender_busy = 1'b0;
        repeat (hdlc_tx_pkg::MAX_FRAME_BYTES + 2)
            send_word(hdlc_tx_pkg::OP_LOAD, pick_frame_byte());
        send_word(hdlc_tx_pkg::OP_START, 8'h00);
        repeat (60) send_word(hdlc_tx_pkg::OP_TICK, 8'($urandom));
        send_word(hdlc_tx_pkg::OP_STOP, 8'h00);
        sender_busy = 1'b1;
    endtask

    // long preamble on a one-byte frame
    task automatic test_long_preamble();
        write_preamble(8'd63);
        receiver_busy = 1'b0;
        send_word(hdlc_tx_pkg::OP_LOAD, 8'($urandom));
        send_word(hdlc_tx_pkg::OP_START, 8'h00);
        tick_out(1'b0);
        receiver_busy = 1'b1;
        write_preamble(8'd0);
    endtask

    // mostly complete frames with random content, some noise and aborts
    task automatic test_random_frames();
        int  goal;
        int  nbytes;
        bit  noisy;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal) begin
            if ($urandom_range(0, 5) == 0) begin
                if ($urandom_range(0, 9) == 0)
                    write_preamble(8'($urandom_range(8, 40)));
                else
                    write_preamble(8'($urandom_range(0, 4)));
            end
            // idling patterns change per frame, including no idling at all
            sender_busy   = ($urandom_range(0, 3) != 0);
            receiver_busy = ($urandom_range(0, 3) != 0);
            noisy         = ($urandom_range(0, 3) == 0);
            nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                 : $urandom_range(1, 4);
            repeat (nbytes) send_word(hdlc_tx_pkg::OP_LOAD, pick_frame_byte());
            // stray command before the start, any opcode
            if ($urandom_range(0, 7) == 0)
                send_word(hdlc_tx_pkg::op_t'($urandom_range(0, 3)), 8'($urandom));
            send_word(hdlc_tx_pkg::OP_START, 8'($urandom));
            tick_out(noisy);
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_commands();
        test_stuffed_tail();
        test_restart_and_abort();
        test_store_full();
        test_long_preamble();
        test_random_frames();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
